[hdl/gf2m_locator_root_search_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the locator root search
// Shared wrappers for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef GF2M_LOCATOR_ROOT_SEARCH_ASSERT_SVH
`define GF2M_LOCATOR_ROOT_SEARCH_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define GF2MLRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define GF2MLRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gf2mlrs_pkg.sv]
// ----------------------------------------------------------------------------
// gf2mlrs_pkg
// Shared types, widths and constants of the locator root search.
// ----------------------------------------------------------------------------
package gf2mlrs_pkg;

   // Fixed field widths of the channels
   localparam int unsigned OP_W      = 2;
   localparam int unsigned INDEX_W   = 7;
   localparam int unsigned ELEM_W    = 13;
   localparam int unsigned COUNT_W   = 14;
   localparam int unsigned MODULUS_W = 14;

   // x^13 + x^4 + x^3 + x + 1
   localparam logic [MODULUS_W-1:0] MODULUS_RESET = 14'd8219;

   // Parameter defaults
   localparam int unsigned FIELD_BITS_DEF = 13;
   localparam int unsigned MAX_DEGREE_DEF = 64;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_TEST   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   // Classified command handed from front to back
   typedef struct packed {
      op_type op;
      logic   load_ok;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HORNER,
      ST_CHECK,
      ST_SCAN,
      ST_REPLY
   } st_type;

   // Upper bound of the root count for a field of fb bits
   function automatic int unsigned count_cap(input int unsigned fb);
      count_cap = (fb >= COUNT_W) ? ((1 << COUNT_W) - 1) : (1 << fb);
   endfunction

endpackage

[hdl/gf2mlrs_front.sv]
// ----------------------------------------------------------------------------
// gf2mlrs_front
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module gf2mlrs_front #(
   parameter int unsigned FIELD_BITS = gf2mlrs_pkg::FIELD_BITS_DEF,
   parameter int unsigned MAX_DEGREE = gf2mlrs_pkg::MAX_DEGREE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gf2mlrs_pkg::OP_W-1:0]           req_op,
   input  logic [gf2mlrs_pkg::INDEX_W-1:0]        req_coef_index,
   input  logic [gf2mlrs_pkg::ELEM_W-1:0]         req_coef_value,
   input  logic [gf2mlrs_pkg::ELEM_W-1:0]         req_element,
   input  logic                                   tbl_busy,
   input  logic                                   cmd_take,
   output logic                                   cmd_valid,
   output gf2mlrs_pkg::cmd_type                   cmd,
   output logic [$clog2(MAX_DEGREE+1)-1:0]        cmd_addr,
   output logic [FIELD_BITS-1:0]                  cmd_operand
);
   import gf2mlrs_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_DEGREE + 1);
   localparam int unsigned IDX_XW = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
   localparam int unsigned VAL_XW = (FIELD_BITS > ELEM_W) ? FIELD_BITS : ELEM_W;
   localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic [IDX_XW-1:0]     idx_x;
   logic [VAL_XW-1:0]     val_x;
   logic [VAL_XW-1:0]     elm_x;
   op_type                in_op;
   cmd_type               entry_cmd_in;
   logic [ADDR_W-1:0]     entry_addr_in;
   logic [FIELD_BITS-1:0] entry_opnd_in;

   cmd_type               q_cmd_ff  [QUEUE_DEPTH];
   logic [ADDR_W-1:0]     q_addr_ff [QUEUE_DEPTH];
   logic [FIELD_BITS-1:0] q_opnd_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push;
   logic             full;

   // Classify the incoming word
   always_comb begin
      idx_x                = IDX_XW'(req_coef_index);
      val_x                = VAL_XW'(req_coef_value);
      elm_x                = VAL_XW'(req_element);
      in_op                = op_type'(req_op);
      entry_cmd_in.op      = in_op;
      entry_cmd_in.load_ok = (in_op == OP_LOAD) && (idx_x <= IDX_XW'(MAX_DEGREE));
      entry_addr_in        = idx_x[ADDR_W-1:0];
      case (in_op)
         OP_LOAD: begin
            entry_opnd_in = val_x[FIELD_BITS-1:0];
         end
         OP_TEST: begin
            entry_opnd_in = elm_x[FIELD_BITS-1:0];
         end
         default: begin
            entry_opnd_in = '0;
         end
      endcase
   end

   // Queue control: stall when full or while the reduction table rebuilds
   always_comb begin
      full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
      req_stall = full | tbl_busy;
      push      = req_valid & ~req_stall;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !cmd_take) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && cmd_take) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff]  <= entry_cmd_in;
         q_addr_ff[wr_ptr_ff] <= entry_addr_in;
         q_opnd_ff[wr_ptr_ff] <= entry_opnd_in;
      end
   end

   // Present the head of the queue
   assign cmd_valid   = (fill_ff != '0);
   assign cmd         = q_cmd_ff[rd_ptr_ff];
   assign cmd_addr    = q_addr_ff[rd_ptr_ff];
   assign cmd_operand = q_opnd_ff[rd_ptr_ff];

endmodule

[hdl/gf2mlrs_gfmul.sv]
// ----------------------------------------------------------------------------
// gf2mlrs_gfmul
// Field modulus register, reduction table and the shared GF(2^m) multiplier.
// ----------------------------------------------------------------------------
module gf2mlrs_gfmul #(
   parameter int unsigned FIELD_BITS = gf2mlrs_pkg::FIELD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gf2mlrs_pkg::MODULUS_W-1:0]   csr_field_modulus,
   input  logic [FIELD_BITS-1:0]               mul_a,
   input  logic [FIELD_BITS-1:0]               mul_b,
   output logic [FIELD_BITS-1:0]               mul_p,
   output logic                                tbl_busy
);
   import gf2mlrs_pkg::*;

   // Table entry j holds x^(FIELD_BITS+j) reduced
   localparam int unsigned TBL_N  = FIELD_BITS - 1;
   localparam int unsigned CNT_W  = $clog2(TBL_N + 1);
   localparam int unsigned MOD_XW = (FIELD_BITS > MODULUS_W) ? FIELD_BITS : MODULUS_W;
   localparam int unsigned PROD_W = 2 * FIELD_BITS - 1;

   logic [MODULUS_W-1:0]  mod_ff, mod_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0] tbl_ff [TBL_N];
   logic [FIELD_BITS-1:0] tbl_new;
   logic [FIELD_BITS-1:0] top_shl;
   logic                  tbl_shift;
   logic [MOD_XW-1:0]     mod_x;
   logic [FIELD_BITS-1:0] feedback;
   logic [PROD_W-1:0]     prod;
   logic [FIELD_BITS-1:0] red;

   assign csr_ready = 1'b1;
   assign tbl_busy  = (cnt_ff != '0);

   // Take register writes and step the table rebuild
   always_comb begin
      mod_x     = MOD_XW'(mod_ff);
      feedback  = mod_x[FIELD_BITS-1:0];
      top_shl   = {tbl_ff[TBL_N-1][FIELD_BITS-2:0], 1'b0};
      tbl_new   = tbl_ff[TBL_N-1][FIELD_BITS-1] ? (top_shl ^ feedback) : top_shl;
      if (cnt_ff == CNT_W'(TBL_N)) begin
         tbl_new = feedback;
      end
      mod_in    = mod_ff;
      cnt_in    = cnt_ff;
      tbl_shift = 1'b0;
      if (csr_valid && csr_ready) begin
         mod_in = csr_field_modulus;
         cnt_in = CNT_W'(TBL_N);
      end else if (cnt_ff != '0) begin
         tbl_shift = 1'b1;
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
         cnt_ff <= CNT_W'(TBL_N);
      end else begin
         mod_ff <= mod_in;
         cnt_ff <= cnt_in;
      end
   end

   // Shift each new power in at the top
   always_ff @(posedge clock) begin
      if (tbl_shift) begin
         for (int i = 0; i < TBL_N - 1; i++) begin
            tbl_ff[i] <= tbl_ff[i + 1];
         end
         tbl_ff[TBL_N-1] <= tbl_new;
      end
   end

   // Carry-less product, then fold the high bits through the table
   always_comb begin
      prod = '0;
      for (int i = 0; i < FIELD_BITS; i++) begin
         if (mul_b[i]) begin
            prod = prod ^ (PROD_W'(mul_a) << i);
         end
      end
      red = prod[FIELD_BITS-1:0];
      for (int j = 0; j < TBL_N; j++) begin
         if (prod[FIELD_BITS + j]) begin
            red = red ^ tbl_ff[j];
         end
      end
      mul_p = red;
   end

endmodule

[hdl/gf2mlrs_back.sv]
// ----------------------------------------------------------------------------
// gf2mlrs_back
// Coefficient store, Horner sequencer, degree scan, root count and result
// register.
// ----------------------------------------------------------------------------
module gf2mlrs_back #(
   parameter int unsigned FIELD_BITS = gf2mlrs_pkg::FIELD_BITS_DEF,
   parameter int unsigned MAX_DEGREE = gf2mlrs_pkg::MAX_DEGREE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  gf2mlrs_pkg::cmd_type                cmd,
   input  logic [$clog2(MAX_DEGREE+1)-1:0]     cmd_addr,
   input  logic [FIELD_BITS-1:0]               cmd_operand,
   output logic                                cmd_take,
   input  logic                                tbl_busy,
   output logic [FIELD_BITS-1:0]               mul_a,
   output logic [FIELD_BITS-1:0]               mul_b,
   input  logic [FIELD_BITS-1:0]               mul_p,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_root,
   output logic [gf2mlrs_pkg::COUNT_W-1:0]     rsp_root_count,
   output logic                                rsp_failed,
   output logic                                rsp_verdict_valid
);
   import gf2mlrs_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_DEGREE + 1);
   localparam int unsigned DEPTH  = MAX_DEGREE + 1;
   localparam int unsigned CAP    = count_cap(FIELD_BITS);

   st_type                state_ff, state_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic                  issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  last_ff, last_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [FIELD_BITS-1:0] x_ff, x_in;
   logic [FIELD_BITS-1:0] rd_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [DEPTH-1:0]      nz_ff, nz_in;
   logic                  res_root_ff, res_root_in;
   logic                  res_fail_ff, res_fail_in;
   logic                  res_verd_ff, res_verd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_root_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_fail_ff;
   logic                  rsp_verd_ff;

   logic [FIELD_BITS-1:0] mem [DEPTH];
   logic                  mem_we;
   logic                  rd_en;
   logic                  out_free;
   logic                  out_load;

   assign mul_a = acc_ff;
   assign mul_b = x_ff;

   // Sequence one command at a time
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      issue_in    = issue_ff;
      rd_vld_in   = 1'b0;
      last_in     = last_ff;
      acc_in      = acc_ff;
      x_in        = x_ff;
      count_in    = count_ff;
      nz_in       = nz_ff;
      res_root_in = res_root_ff;
      res_fail_in = res_fail_ff;
      res_verd_in = res_verd_ff;
      cmd_take    = 1'b0;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      out_load    = 1'b0;
      out_free    = ~rsp_valid_ff | ~rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !tbl_busy) begin
               cmd_take    = 1'b1;
               res_root_in = 1'b0;
               res_fail_in = 1'b0;
               res_verd_in = 1'b0;
               case (cmd.op)
                  OP_CLEAR: begin
                     count_in = '0;
                     nz_in    = '0;
                     state_in = ST_REPLY;
                  end
                  OP_LOAD: begin
                     if (cmd.load_ok) begin
                        mem_we          = 1'b1;
                        nz_in[cmd_addr] = |cmd_operand;
                     end
                     state_in = ST_REPLY;
                  end
                  OP_TEST: begin
                     x_in     = cmd_operand;
                     acc_in   = '0;
                     idx_in   = ADDR_W'(MAX_DEGREE);
                     issue_in = 1'b1;
                     state_in = ST_HORNER;
                  end
                  OP_FINISH: begin
                     idx_in      = ADDR_W'(MAX_DEGREE);
                     res_verd_in = 1'b1;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end

         // Read coefficients top down, fold each one into the accumulator
         ST_HORNER: begin
            rd_vld_in = issue_ff;
            if (issue_ff) begin
               rd_en   = 1'b1;
               last_in = (idx_ff == '0);
               if (idx_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            if (rd_vld_ff) begin
               acc_in = mul_p ^ rd_ff;
               if (last_ff) begin
                  state_in = ST_CHECK;
               end
            end
         end

         // Count a root, saturating at the cap
         ST_CHECK: begin
            if (acc_ff == '0) begin
               res_root_in = 1'b1;
               if (count_ff < COUNT_W'(CAP)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = ST_REPLY;
         end

         // Find the highest nonzero coefficient and compare with the count
         ST_SCAN: begin
            if (nz_ff[idx_ff]) begin
               res_fail_in = (count_ff != COUNT_W'(idx_ff));
               state_in    = ST_REPLY;
            end else if (idx_ff == '0) begin
               state_in = ST_REPLY;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      res_root_ff <= res_root_in;
      res_fail_ff <= res_fail_in;
      res_verd_ff <= res_verd_in;
   end

   // Coefficient store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_addr] <= cmd_operand;
      end
      if (rd_en) begin
         rd_ff <= nz_ff[idx_ff] ? mem[idx_ff] : '0;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_root_ff  <= res_root_ff;
         rsp_count_ff <= count_ff;
         rsp_fail_ff  <= res_fail_ff;
         rsp_verd_ff  <= res_verd_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_root       = rsp_root_ff;
   assign rsp_root_count    = rsp_count_ff;
   assign rsp_failed        = rsp_fail_ff;
   assign rsp_verdict_valid = rsp_verd_ff;

endmodule

[hdl/gf2m_locator_root_search.sv]
// ----------------------------------------------------------------------------
// gf2m_locator_root_search
// Root search for an error locator polynomial over GF(2^m).
// ----------------------------------------------------------------------------
// Request words carry op (clear, load coefficient, test element, finish)
// with their operands; each request gives exactly one response word with
// is_root, root_count, failed and verdict_valid. Both channels move a word
// at an edge where valid is high and stall is low. The user must write
// the field modulus over the csr channel only while the block is idle;
// the block does not enforce this, and csr_ready is always high. A
// two-word queue sits between the request side and the engine, and the
// response register lets the next request in while a response waits.
// A test reads one coefficient and makes one pass of the shared field
// multiplier per cycle, then makes the last fold, the root check and the
// reply; the engine takes the next command only once a test is through.
// After reset, and after each modulus write, the reduction table rebuilds
// with req_stall high; reset empties the store, zeroes the count and
// loads the default modulus. While rsp_stall is high the response holds,
// the engine waits at its next reply, and req_stall rises once the queue
// fills.
// ----------------------------------------------------------------------------
module gf2m_locator_root_search #(
   parameter int unsigned FIELD_BITS = gf2mlrs_pkg::FIELD_BITS_DEF,
   parameter int unsigned MAX_DEGREE = gf2mlrs_pkg::MAX_DEGREE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gf2mlrs_pkg::OP_W-1:0]        req_op,
   input  logic [gf2mlrs_pkg::INDEX_W-1:0]     req_coef_index,
   input  logic [gf2mlrs_pkg::ELEM_W-1:0]      req_coef_value,
   input  logic [gf2mlrs_pkg::ELEM_W-1:0]      req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_root,
   output logic [gf2mlrs_pkg::COUNT_W-1:0]     rsp_root_count,
   output logic                                rsp_failed,
   output logic                                rsp_verdict_valid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gf2mlrs_pkg::MODULUS_W-1:0]   csr_field_modulus
);
   import gf2mlrs_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_DEGREE + 1);

   logic                  tbl_busy;
   logic                  cmd_valid;
   logic                  cmd_take;
   cmd_type               cmd;
   logic [ADDR_W-1:0]     cmd_addr;
   logic [FIELD_BITS-1:0] cmd_operand;
   logic [FIELD_BITS-1:0] mul_a;
   logic [FIELD_BITS-1:0] mul_b;
   logic [FIELD_BITS-1:0] mul_p;

   gf2mlrs_front #(
      .FIELD_BITS (FIELD_BITS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_element    (req_element),
      .tbl_busy       (tbl_busy),
      .cmd_take       (cmd_take),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_addr       (cmd_addr),
      .cmd_operand    (cmd_operand)
   );

   gf2mlrs_gfmul #(
      .FIELD_BITS (FIELD_BITS)
   ) u_gfmul (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_field_modulus (csr_field_modulus),
      .mul_a             (mul_a),
      .mul_b             (mul_b),
      .mul_p             (mul_p),
      .tbl_busy          (tbl_busy)
   );

   gf2mlrs_back #(
      .FIELD_BITS (FIELD_BITS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_addr          (cmd_addr),
      .cmd_operand       (cmd_operand),
      .cmd_take          (cmd_take),
      .tbl_busy          (tbl_busy),
      .mul_a             (mul_a),
      .mul_b             (mul_b),
      .mul_p             (mul_p),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_root       (rsp_is_root),
      .rsp_root_count    (rsp_root_count),
      .rsp_failed        (rsp_failed),
      .rsp_verdict_valid (rsp_verdict_valid)
   );

endmodule

[hdl/gf2mlrs_check.sv]
// ----------------------------------------------------------------------------
// gf2mlrs_check
// Port-level checks of the locator root search, bound to the top level.
// ----------------------------------------------------------------------------
`include "gf2m_locator_root_search_assert.svh"

module gf2mlrs_check #(
   parameter int unsigned FIELD_BITS = gf2mlrs_pkg::FIELD_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_is_root,
   input logic [gf2mlrs_pkg::COUNT_W-1:0]     rsp_root_count,
   input logic                                rsp_failed,
   input logic                                rsp_verdict_valid
);
   import gf2mlrs_pkg::*;

   localparam int unsigned CAP = count_cap(FIELD_BITS);

   // Hold a stalled response word
   `GF2MLRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_is_root) && $stable(rsp_root_count) && $stable(rsp_failed) && $stable(rsp_verdict_valid), "stalled response changed")

   // Failure is only reported on a verdict
   `GF2MLRS_ASSERT_NOW(a_fail_verdict, clock, reset, rsp_valid && rsp_failed, rsp_verdict_valid, "failed without verdict")

   // A verdict never flags a root
   `GF2MLRS_ASSERT_NOW(a_verdict_root, clock, reset, rsp_valid && rsp_verdict_valid, !rsp_is_root, "root flagged on verdict")

   // A found root leaves a nonzero count
   `GF2MLRS_ASSERT_NOW(a_root_count, clock, reset, rsp_valid && rsp_is_root, rsp_root_count != '0, "root with zero count")

   // The count saturates at its cap
   `GF2MLRS_ASSERT_NOW(a_count_cap, clock, reset, rsp_valid, rsp_root_count <= COUNT_W'(CAP), "root count above cap")

endmodule

bind gf2m_locator_root_search gf2mlrs_check #(
   .FIELD_BITS (FIELD_BITS)
) u_check (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_is_root       (rsp_is_root),
   .rsp_root_count    (rsp_root_count),
   .rsp_failed        (rsp_failed),
   .rsp_verdict_valid (rsp_verdict_valid)
);
